>>> src/qcf_pkg.sv
// Shared types, constants and fixed-point helpers for the quaternion attitude filter.
// No dependencies; used by the lane multiplier and the top level.
`timescale 1ns / 1ps
`default_nettype none

package qcf_pkg;

  // One multiply request for a lane: signed operands, right shift of the magnitude.
  typedef struct packed {
    logic signed [32:0] a;
    logic signed [32:0] b;
    logic [5:0]         sh;
  } lane_req_t;

  localparam int NLANE = 4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SKIP   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam logic [1:0] CFG_PROP  = 2'd0;
  localparam logic [1:0] CFG_INTEG = 2'd1;

  localparam logic [31:0] PROP_RST  = 32'd17560153;
  localparam logic [31:0] INTEG_RST = 32'd18379649;

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  localparam logic signed [63:0] MAX32 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] MIN32 = -64'sh0000_0000_8000_0000;
  localparam logic signed [63:0] POS30 = 64'sh0000_0000_4000_0000;
  localparam logic signed [63:0] NEG30 = -64'sh0000_0000_4000_0000;

  // Shift right, rounding toward zero.
  function automatic logic signed [63:0] shr0(input logic signed [63:0] v,
                                              input logic [5:0] s);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = m >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > MAX32) r = 32'sh7FFF_FFFF;
    else if (v < MIN32) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] clamp30(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > POS30) r = ONE_Q30;
    else if (v < NEG30) r = -ONE_Q30;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/qcf_lane.sv
// One multiplier lane: 32x32 magnitude product, then truncating shift and sign.
// Depends on qcf_pkg for the request type. The product is registered, then the signed result.
`timescale 1ns / 1ps
`default_nettype none

module qcf_lane (
  input  wire logic              clk,
  input  wire qcf_pkg::lane_req_t req,
  output logic signed [63:0]     res
);

  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] prod_r;
  logic        neg_r;
  logic [5:0]  sh_r;
  logic [63:0] shd;

  always_comb begin
    ma  = req.a[32] ? 32'(-req.a) : req.a[31:0];
    mb  = req.b[32] ? 32'(-req.b) : req.b[31:0];
    shd = prod_r >> sh_r;
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(ma) * 64'(mb);
    neg_r  <= req.a[32] ^ req.b[32];
    sh_r   <= req.sh;
    res    <= neg_r ? -$signed(shd) : $signed(shd);
  end

endmodule

`default_nettype wire

>>> src/qcf_sqrt.sv
// Floor square root of a 64-bit value, two radicand bits per cycle.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module qcf_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] val,
  output logic [31:0]      root,
  output logic             done
);

  logic [63:0] v_r;
  logic [35:0] rem_r;
  logic [31:0] root_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;

  always_comb begin
    rem_sh = {rem_r[33:0], v_r[63:62]};
    trial  = {2'b00, root_r, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= val;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      v_r    <= v_r << 2;
      rem_r  <= ge ? rem_sh - trial : rem_sh;
      root_r <= {root_r[30:0], ge};
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

`default_nettype wire

>>> src/qcf_div.sv
// Divider lane: floor(num * 2^30 / den) for num <= den, one quotient bit per cycle.
// No package dependencies. 31 iterations; done is registered together with the last quotient bit.
`timescale 1ns / 1ps
`default_nettype none

module qcf_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [30:0] num,
  input  wire logic [31:0] den,
  output logic [30:0]      quo,
  output logic             done
);

  logic [31:0] rem_r;
  logic [30:0] quo_r;
  logic        feed_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] tmp;
  logic [32:0] dext;
  logic        ge;

  always_comb begin
    tmp  = {rem_r, feed_r};
    dext = {1'b0, den};
    ge   = tmp >= dext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // the dividend is num followed by 30 zero bits; the top quotient bits are known zero
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {2'b00, num[30:1]};
      feed_r <= num[0];
      quo_r  <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? 32'(tmp - dext) : tmp[31:0];
      feed_r <= 1'b0;
      quo_r  <= {quo_r[29:0], ge};
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

`default_nettype wire

>>> src/quaternion_complementary_attitude_filter.sv
// Quaternion complementary (PI) attitude filter, fixed point.
// Depends on qcf_pkg, qcf_lane, qcf_sqrt and qcf_div.
//
// Usage:
//   in_*  : one request per accepted beat. in_tuser[0] is op (0 update, 1 load).
//   out_* : one result per request: attitude quaternion in Q2.30 and a status code.
//   cfg_* : register writes (index 0 proportional gain, 1 integral gain), always ready.
// Structure: four multiplier lanes share the products of each phase, four divider lanes
//   scale the components of a vector, and one iterative square root sets the pace.
//   Each normalization runs the root and then the divide. An update runs three of
//   them, fewer when the acceleration is zero; a load runs one. One request is in
//   flight at a time; in_tready is high only while the block is idle.
// Reset: attitude becomes the identity, the error integral zero, gains their defaults.
// Stall: a finished result sits in the output register; if the receiver still holds
//   the previous one, the block waits before taking the next request.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_complementary_attitude_filter (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // step_time[23:0] rate_x[55:24] rate_y[87:56] rate_z[119:88] acc_x[151:120]
  // acc_y[183:152] acc_z[215:184] load_w[247:216] load_i[279:248] load_j[311:280]
  // load_k[343:312]
  input  wire logic [343:0] in_tdata,
  input  wire logic [0:0]   in_tuser,   // op[0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // att_w[31:0] att_i[63:32] att_j[95:64] att_k[127:96]
  output logic [127:0]      out_tdata,
  output logic [1:0]        out_tuser,  // status[1:0]
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  typedef enum logic [19:0] {
    S_IDLE = 20'h00001,
    S_UPM  = 20'h00002,
    S_UPC  = 20'h00004,
    S_NSH  = 20'h00008,
    S_NSQ  = 20'h00010,
    S_NSUM = 20'h00020,
    S_NRT  = 20'h00040,
    S_NDV  = 20'h00080,
    S_NRET = 20'h00100,
    S_CRM  = 20'h00200,
    S_CRC  = 20'h00400,
    S_INM  = 20'h00800,
    S_INC  = 20'h01000,
    S_WM   = 20'h02000,
    S_WC   = 20'h04000,
    S_THM  = 20'h08000,
    S_THC  = 20'h10000,
    S_QM   = 20'h20000,
    S_QC   = 20'h40000,
    S_DONE = 20'h80000
  } state_t;

  typedef enum logic [1:0] {
    RET_ACC = 2'd0,
    RET_UP  = 2'd1,
    RET_Q   = 2'd2
  } ret_t;

  state_t state_r, state_nxt;
  ret_t   ret_r;
  logic [2:0] cnt_r;

  logic               op_r;
  logic [23:0]        dt_r;
  logic signed [31:0] rate_r [3];
  logic signed [31:0] att_r [4];
  logic signed [31:0] integ_r [3];
  logic [31:0]        prop_r;
  logic [31:0]        igain_r;
  logic signed [31:0] up_r [3];
  logic signed [31:0] d_r [3];
  logic signed [31:0] p_r [3];
  logic signed [31:0] e_r [3];
  logic signed [31:0] ws_r [3];
  logic signed [31:0] th_r [3];
  logic signed [34:0] nv_r [4];
  logic [30:0]        cm_r [4];
  logic               cs_r [4];
  logic signed [63:0] pr_r [12];
  logic               nfail_r;
  logic [1:0]         status_r;
  logic               out_valid_r;
  logic [127:0]       out_data_r;
  logic [1:0]         out_user_r;

  qcf_pkg::lane_req_t lreq [4];
  logic signed [63:0] lres [4];
  logic               is_mult;
  logic               in_acc;
  logic               out_free;

  logic [63:0]        sumv;
  logic               sqrt_start;
  logic [31:0]        sqrt_root;
  logic               sqrt_done;
  logic               div_start;
  logic [30:0]        div_q [4];
  logic               div_done [4];

  logic [34:0]        nmag [4];
  logic [34:0]        orv;
  logic [2:0]         kshift;
  logic signed [31:0] nres [4];

  logic signed [63:0] t_up [3];
  logic signed [63:0] s_q [4];
  logic signed [31:0] acc_in [3];
  logic signed [31:0] ld_in [4];

  function automatic qcf_pkg::lane_req_t mk(input logic signed [32:0] a,
                                            input logic signed [32:0] b,
                                            input logic [5:0] sh);
    qcf_pkg::lane_req_t r;
    r.a  = a;
    r.b  = b;
    r.sh = sh;
    return r;
  endfunction

  function automatic logic signed [32:0] x33(input logic signed [31:0] v);
    return 33'(v);
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign is_mult = (state_r == S_UPM) || (state_r == S_NSQ) || (state_r == S_CRM) ||
                   (state_r == S_INM) || (state_r == S_WM) || (state_r == S_THM) ||
                   (state_r == S_QM);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_in[i] = in_tdata[120 + 32*i +: 32];
    end
    for (int i = 0; i < 4; i++) begin
      ld_in[i] = in_tdata[216 + 32*i +: 32];
    end
  end

  // operand routing for the lanes, by phase and product group
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      lreq[l] = '0;
    end
    case (state_r)
      S_UPM: begin
        if (cnt_r == 3'd0) begin
          lreq[0] = mk(x33(att_r[1]), x33(att_r[3]), 6'd0);
          lreq[1] = mk(x33(att_r[0]), x33(att_r[2]), 6'd0);
          lreq[2] = mk(x33(att_r[2]), x33(att_r[3]), 6'd0);
          lreq[3] = mk(x33(att_r[0]), x33(att_r[1]), 6'd0);
        end else if (cnt_r == 3'd1) begin
          for (int l = 0; l < 4; l++) begin
            lreq[l] = mk(x33(att_r[l]), x33(att_r[l]), 6'd0);
          end
        end
      end
      S_NSQ: begin
        if (cnt_r == 3'd0) begin
          for (int l = 0; l < 4; l++) begin
            lreq[l] = mk($signed({2'b00, cm_r[l]}), $signed({2'b00, cm_r[l]}), 6'd0);
          end
        end
      end
      S_CRM: begin
        if (cnt_r == 3'd0) begin
          lreq[0] = mk(x33(d_r[1]), x33(p_r[2]), 6'd0);
          lreq[1] = mk(x33(d_r[2]), x33(p_r[1]), 6'd0);
          lreq[2] = mk(x33(d_r[2]), x33(p_r[0]), 6'd0);
          lreq[3] = mk(x33(d_r[0]), x33(p_r[2]), 6'd0);
        end else if (cnt_r == 3'd1) begin
          lreq[0] = mk(x33(d_r[0]), x33(p_r[1]), 6'd0);
          lreq[1] = mk(x33(d_r[1]), x33(p_r[0]), 6'd0);
        end
      end
      S_INM: begin
        if (cnt_r == 3'd0) begin
          for (int l = 0; l < 3; l++) begin
            lreq[l] = mk(x33(e_r[l]), $signed({9'd0, dt_r}), 6'd30);
          end
        end
      end
      S_WM: begin
        if (cnt_r == 3'd0) begin
          for (int l = 0; l < 3; l++) begin
            lreq[l] = mk(x33(e_r[l]), $signed({1'b0, prop_r}), 6'd38);
          end
          lreq[3] = mk(x33(integ_r[0]), $signed({1'b0, igain_r}), 6'd32);
        end else if (cnt_r == 3'd1) begin
          lreq[0] = mk(x33(integ_r[1]), $signed({1'b0, igain_r}), 6'd32);
          lreq[1] = mk(x33(integ_r[2]), $signed({1'b0, igain_r}), 6'd32);
        end
      end
      S_THM: begin
        if (cnt_r == 3'd0) begin
          for (int l = 0; l < 3; l++) begin
            lreq[l] = mk(x33(ws_r[l]), $signed({9'd0, dt_r}), 6'd10);
          end
        end
      end
      S_QM: begin
        if (cnt_r == 3'd0) begin
          lreq[0] = mk(x33(att_r[1]), x33(th_r[0]), 6'd0);
          lreq[1] = mk(x33(att_r[2]), x33(th_r[1]), 6'd0);
          lreq[2] = mk(x33(att_r[3]), x33(th_r[2]), 6'd0);
          lreq[3] = mk(x33(att_r[0]), x33(th_r[0]), 6'd0);
        end else if (cnt_r == 3'd1) begin
          lreq[0] = mk(x33(att_r[3]), x33(th_r[1]), 6'd0);
          lreq[1] = mk(x33(att_r[2]), x33(th_r[2]), 6'd0);
          lreq[2] = mk(x33(att_r[3]), x33(th_r[0]), 6'd0);
          lreq[3] = mk(x33(att_r[0]), x33(th_r[1]), 6'd0);
        end else if (cnt_r == 3'd2) begin
          lreq[0] = mk(x33(att_r[1]), x33(th_r[2]), 6'd0);
          lreq[1] = mk(x33(att_r[2]), x33(th_r[0]), 6'd0);
          lreq[2] = mk(x33(att_r[1]), x33(th_r[1]), 6'd0);
          lreq[3] = mk(x33(att_r[0]), x33(th_r[2]), 6'd0);
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar l = 0; l < qcf_pkg::NLANE; l++) begin : g_lane
    qcf_lane u_lane (
      .clk (clk),
      .req (lreq[l]),
      .res (lres[l])
    );
    qcf_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (div_start),
      .num   (cm_r[l]),
      .den   (sqrt_root),
      .quo   (div_q[l]),
      .done  (div_done[l])
    );
  end

  assign sumv       = 64'(pr_r[0]) + 64'(pr_r[1]) + 64'(pr_r[2]) + 64'(pr_r[3]);
  assign sqrt_start = (state_r == S_NSUM) && (sumv != 64'd0);
  assign div_start  = (state_r == S_NRT) && sqrt_done;

  qcf_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .val   (sumv),
    .root  (sqrt_root),
    .done  (sqrt_done)
  );

  // merging arithmetic for each phase
  always_comb begin
    orv = '0;
    for (int i = 0; i < 4; i++) begin
      nmag[i] = nv_r[i][34] ? 35'(-nv_r[i]) : 35'(nv_r[i]);
      orv     = orv | nmag[i];
      nres[i] = cs_r[i] ? -$signed({1'b0, div_q[i]}) : $signed({1'b0, div_q[i]});
    end
    // halve until every magnitude is below 2^31
    if (orv[34]) kshift = 3'd4;
    else if (orv[33]) kshift = 3'd3;
    else if (orv[32]) kshift = 3'd2;
    else if (orv[31]) kshift = 3'd1;
    else kshift = 3'd0;

    t_up[0] = (pr_r[0] - pr_r[1]) <<< 1;
    t_up[1] = (pr_r[2] + pr_r[3]) <<< 1;
    t_up[2] = pr_r[4] - pr_r[5] - pr_r[6] + pr_r[7];

    s_q[0] = -pr_r[0] - pr_r[1] - pr_r[2];
    s_q[1] = pr_r[3] - pr_r[4] + pr_r[5];
    s_q[2] = pr_r[6] + pr_r[7] - pr_r[8];
    s_q[3] = -pr_r[9] + pr_r[10] + pr_r[11];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = in_tuser[0] ? S_NSH : S_UPM;
      S_UPM:  if (cnt_r == 3'd4) state_nxt = S_UPC;
      S_UPC:  state_nxt = S_NSH;
      S_NSH:  state_nxt = S_NSQ;
      S_NSQ:  if (cnt_r == 3'd4) state_nxt = S_NSUM;
      S_NSUM: state_nxt = (sumv != 64'd0) ? S_NRT : S_NRET;
      S_NRT:  if (sqrt_done) state_nxt = S_NDV;
      S_NDV:  if (div_done[0]) state_nxt = S_NRET;
      S_NRET: begin
        case (ret_r)
          RET_ACC: state_nxt = nfail_r ? S_INM : S_NSH;
          RET_UP:  state_nxt = nfail_r ? S_INM : S_CRM;
          default: state_nxt = S_DONE;
        endcase
      end
      S_CRM:  if (cnt_r == 3'd4) state_nxt = S_CRC;
      S_CRC:  state_nxt = S_INM;
      S_INM:  if (cnt_r == 3'd4) state_nxt = S_INC;
      S_INC:  state_nxt = S_WM;
      S_WM:   if (cnt_r == 3'd4) state_nxt = S_WC;
      S_WC:   state_nxt = S_THM;
      S_THM:  if (cnt_r == 3'd4) state_nxt = S_THC;
      S_THC:  state_nxt = S_QM;
      S_QM:   if (cnt_r == 3'd4) state_nxt = S_QC;
      S_QC:   state_nxt = S_NSH;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= RET_ACC;
      cnt_r       <= '0;
      nfail_r     <= 1'b0;
      status_r    <= qcf_pkg::ST_OK;
      out_valid_r <= 1'b0;
      prop_r      <= qcf_pkg::PROP_RST;
      igain_r     <= qcf_pkg::INTEG_RST;
      att_r[0]    <= qcf_pkg::ONE_Q30;
      att_r[1]    <= '0;
      att_r[2]    <= '0;
      att_r[3]    <= '0;
      for (int i = 0; i < 3; i++) begin
        integ_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (is_mult) begin
        cnt_r <= (cnt_r == 3'd4) ? 3'd0 : cnt_r + 3'd1;
      end
      if (cfg_valid) begin
        case (cfg_index)
          qcf_pkg::CFG_PROP:  prop_r  <= cfg_data;
          qcf_pkg::CFG_INTEG: igain_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            status_r <= qcf_pkg::ST_OK;
            ret_r    <= RET_Q;
          end
        end
        S_UPC:  ret_r <= RET_ACC;
        S_NSUM: nfail_r <= (sumv == 64'd0);
        S_NRT:  nfail_r <= 1'b0;
        S_NRET: begin
          case (ret_r)
            RET_ACC: begin
              if (nfail_r) status_r <= qcf_pkg::ST_SKIP;
              else ret_r <= RET_UP;
            end
            RET_UP: begin
              if (nfail_r) status_r <= qcf_pkg::ST_SKIP;
            end
            default: begin
              // fix sign so the scalar part is not negative; keep state on a zero vector
              if (!nfail_r) begin
                for (int i = 0; i < 4; i++) begin
                  att_r[i] <= nres[0][31] ? -nres[i] : nres[i];
                end
              end else if (op_r) begin
                status_r <= qcf_pkg::ST_REJECT;
              end
            end
          endcase
        end
        S_INC: begin
          for (int i = 0; i < 3; i++) begin
            integ_r[i] <= qcf_pkg::sat32(64'(integ_r[i]) + pr_r[i]);
          end
        end
        S_QC:   ret_r <= RET_Q;
        S_DONE: if (out_free) out_valid_r <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (is_mult) begin
      case (cnt_r)
        3'd2: for (int l = 0; l < 4; l++) pr_r[l] <= lres[l];
        3'd3: for (int l = 0; l < 4; l++) pr_r[4 + l] <= lres[l];
        3'd4: for (int l = 0; l < 4; l++) pr_r[8 + l] <= lres[l];
        default: begin
        end
      endcase
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r <= in_tuser[0];
          dt_r <= in_tdata[23:0];
          for (int i = 0; i < 3; i++) begin
            rate_r[i] <= in_tdata[24 + 32*i +: 32];
          end
          if (in_tuser[0]) begin
            for (int i = 0; i < 4; i++) begin
              nv_r[i] <= 35'(ld_in[i]);
            end
          end else begin
            for (int i = 0; i < 3; i++) begin
              nv_r[i] <= 35'(acc_in[i]);
            end
            nv_r[3] <= '0;
          end
        end
      end
      S_UPC: begin
        for (int i = 0; i < 3; i++) begin
          up_r[i] <= qcf_pkg::sat32(qcf_pkg::shr0(t_up[i], 6'd30));
        end
      end
      S_NSH: begin
        for (int i = 0; i < 4; i++) begin
          cm_r[i] <= 31'(nmag[i] >> kshift);
          cs_r[i] <= nv_r[i][34];
        end
      end
      S_NRET: begin
        case (ret_r)
          RET_ACC: begin
            if (nfail_r) begin
              for (int i = 0; i < 3; i++) e_r[i] <= '0;
            end else begin
              for (int i = 0; i < 3; i++) begin
                d_r[i]  <= nres[i];
                nv_r[i] <= 35'(up_r[i]);
              end
              nv_r[3] <= '0;
            end
          end
          RET_UP: begin
            if (nfail_r) begin
              for (int i = 0; i < 3; i++) e_r[i] <= '0;
            end else begin
              for (int i = 0; i < 3; i++) p_r[i] <= nres[i];
            end
          end
          default: begin
          end
        endcase
      end
      S_CRC: begin
        e_r[0] <= qcf_pkg::clamp30(qcf_pkg::shr0(pr_r[0] - pr_r[1], 6'd30));
        e_r[1] <= qcf_pkg::clamp30(qcf_pkg::shr0(pr_r[2] - pr_r[3], 6'd30));
        e_r[2] <= qcf_pkg::clamp30(qcf_pkg::shr0(pr_r[4] - pr_r[5], 6'd30));
      end
      S_WC: begin
        for (int i = 0; i < 3; i++) begin
          ws_r[i] <= qcf_pkg::sat32(64'(rate_r[i]) + pr_r[i] + pr_r[3 + i]);
        end
      end
      S_THC: begin
        for (int i = 0; i < 3; i++) th_r[i] <= qcf_pkg::sat32(pr_r[i]);
      end
      S_QC: begin
        for (int i = 0; i < 4; i++) begin
          nv_r[i] <= 35'(64'(att_r[i]) + qcf_pkg::shr0(s_q[i], 6'd31));
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_data_r <= {att_r[3], att_r[2], att_r[1], att_r[0]};
          out_user_r <= status_r;
        end
      end
      default: begin
      end
    endcase
  end

  a_sqrt_phase: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> state_r == S_NRT)
    else $error("root finished outside its wait phase");

  a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
    div_done[0] |-> state_r == S_NDV)
    else $error("divide finished outside its wait phase");

  a_scalar_sign: assert property (@(posedge clk) disable iff (!rst_n)
    !att_r[0][31])
    else $error("stored attitude has negative scalar part");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("request accepted but sequencer stayed idle");

endmodule

`default_nettype wire
